### rtl/slope_matched_period_detector_macros.svh
// Assertion macros shared by the slope-matched period detector RTL.
`ifndef SLOPE_MATCHED_PERIOD_DETECTOR_MACROS_SVH
`define SLOPE_MATCHED_PERIOD_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spd assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted
`define SPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spd assertion failed: next-cycle check");

`endif

### rtl/spd_pkg.sv
// Shared constants, result types and helper functions of the period detector.
package spd_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [SAMPLE_W-1:0] MIDPOINT   = 8'd127;
    localparam logic [3:0]          MISS_LIMIT = 4'd9;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_TOL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_WINDOW   = 2'd2;

    // Register reset values
    localparam logic [7:0]  SLOPE_TOL_RST    = 8'd3;
    localparam logic [15:0] INTERVAL_TOL_RST = 16'd10;
    localparam logic [15:0] AMP_WINDOW_RST   = 16'd1000;

    typedef struct packed {
        logic        trigger;
        logic        period_valid;
        logic [15:0] period;
    } spd_period_res_t;

    typedef struct packed {
        logic       amp_valid;
        logic [7:0] peak;
    } spd_amp_res_t;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### rtl/spd_period.sv
// Rising-crossing detection, slope matching and period accumulation.
module spd_period #(
    parameter int unsigned EVENT_SLOTS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic [7:0]                sample,
    input  logic [7:0]                slope_tol,
    input  logic [15:0]               interval_tol,
    output spd_pkg::spd_period_res_t  res
);

    localparam int unsigned EC_W = $clog2(EVENT_SLOTS);
    localparam logic [EC_W-1:0] LAST_SLOT = EC_W'(EVENT_SLOTS - 1);

    logic [7:0]      last_sample_reg, last_sample_next;
    logic [15:0]     sample_clock_reg, sample_clock_next;
    logic [EC_W-1:0] event_count_reg, event_count_next;
    logic [7:0]      steepest_reg, steepest_next;
    logic [3:0]      miss_count_reg, miss_count_next;
    logic [15:0]     period_reg, period_next;
    // Event 0 and the running sum of the stored intervals
    logic [15:0]     first_interval_reg, first_interval_next;
    logic [7:0]      first_slope_reg, first_slope_next;
    logic [15:0]     interval_sum_reg, interval_sum_next;

    logic       crossing;
    logic [7:0] slope;
    logic       near_steepest;
    logic       match_first;
    logic [3:0] miss_inc;

    always_comb begin
        crossing      = (last_sample_reg < spd_pkg::MIDPOINT) && (sample >= spd_pkg::MIDPOINT);
        slope         = sample - last_sample_reg;
        near_steepest = spd_pkg::absdiff8(slope, steepest_reg) < slope_tol;
        match_first   = (spd_pkg::absdiff16(first_interval_reg, sample_clock_reg) < interval_tol)
                        && (spd_pkg::absdiff8(first_slope_reg, slope) < slope_tol);
        miss_inc      = miss_count_reg + 4'd1;
    end

    // Next state for one item
    always_comb begin
        logic [15:0] clock_base;
        clock_base          = sample_clock_reg;
        last_sample_next    = sample;
        event_count_next    = event_count_reg;
        steepest_next       = steepest_reg;
        miss_count_next     = miss_count_reg;
        period_next         = period_reg;
        first_interval_next = first_interval_reg;
        first_slope_next    = first_slope_reg;
        interval_sum_next   = interval_sum_reg;
        res.trigger         = 1'b0;
        res.period_valid    = 1'b0;

        if (crossing && near_steepest) begin
            clock_base = '0;
            if (event_count_reg == '0) begin
                first_interval_next = sample_clock_reg;
                first_slope_next    = slope;
                interval_sum_next   = sample_clock_reg;
                event_count_next    = EC_W'(1);
                miss_count_next     = '0;
                res.trigger         = 1'b1;
            end else if (match_first) begin
                period_next         = interval_sum_reg;
                first_interval_next = sample_clock_reg;
                first_slope_next    = slope;
                interval_sum_next   = sample_clock_reg;
                event_count_next    = EC_W'(1);
                miss_count_next     = '0;
                res.trigger         = 1'b1;
                res.period_valid    = 1'b1;
            end else begin
                interval_sum_next = interval_sum_reg + sample_clock_reg;
                if (event_count_reg == LAST_SLOT) begin
                    event_count_next = '0;
                    miss_count_next  = '0;
                    steepest_next    = '0;
                end else begin
                    event_count_next = event_count_reg + EC_W'(1);
                end
            end
        end else if (crossing && (slope > steepest_reg)) begin
            // New steepest slope: restart the event table
            clock_base       = '0;
            steepest_next    = slope;
            miss_count_next  = '0;
            event_count_next = '0;
        end else if (crossing) begin
            // Shallow crossing: count a miss, drop everything after too many
            if (miss_inc > spd_pkg::MISS_LIMIT) begin
                event_count_next = '0;
                miss_count_next  = '0;
                steepest_next    = '0;
            end else begin
                miss_count_next = miss_inc;
            end
        end

        sample_clock_next = clock_base + 16'd1;
        res.period        = period_next;
    end

    // Control and counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg  <= '0;
            sample_clock_reg <= '0;
            event_count_reg  <= '0;
            steepest_reg     <= '0;
            miss_count_reg   <= '0;
            period_reg       <= '0;
        end else if (step) begin
            last_sample_reg  <= last_sample_next;
            sample_clock_reg <= sample_clock_next;
            event_count_reg  <= event_count_next;
            steepest_reg     <= steepest_next;
            miss_count_reg   <= miss_count_next;
            period_reg       <= period_next;
        end
    end

    // Event payload, read only after it has been written
    always_ff @(posedge aclk) begin
        if (step) begin
            first_interval_reg <= first_interval_next;
            first_slope_reg    <= first_slope_next;
            interval_sum_reg   <= interval_sum_next;
        end
    end

endmodule

### rtl/spd_amp.sv
// Peak deviation from the midpoint over a window of samples.
module spd_amp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             sample,
    input  logic [15:0]            amp_window,
    output spd_pkg::spd_amp_res_t  res
);

    logic [15:0] window_count_reg, window_count_next;
    logic [7:0]  running_peak_reg, running_peak_next;
    logic [7:0]  held_peak_reg, held_peak_next;

    always_comb begin
        logic [15:0] count_inc;
        logic [7:0]  dev;
        logic [7:0]  peak_upd;
        count_inc = window_count_reg + 16'd1;
        dev       = spd_pkg::absdiff8(spd_pkg::MIDPOINT, sample);
        peak_upd  = (dev > running_peak_reg) ? dev : running_peak_reg;

        window_count_next = count_inc;
        running_peak_next = peak_upd;
        held_peak_next    = held_peak_reg;
        res.amp_valid     = 1'b0;
        // Close the window on an exact count match
        if (count_inc == amp_window) begin
            window_count_next = '0;
            running_peak_next = '0;
            held_peak_next    = peak_upd;
            res.amp_valid     = 1'b1;
        end
        res.peak = held_peak_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_count_reg <= '0;
            running_peak_reg <= '0;
            held_peak_reg    <= '0;
        end else if (step) begin
            window_count_reg <= window_count_next;
            running_peak_reg <= running_peak_next;
            held_peak_reg    <= held_peak_next;
        end
    end

endmodule

### rtl/slope_matched_period_detector.sv
// Slope-matched period detector: takes one 8-bit converter sample (midpoint 127)
// per item on the s_ stream and returns exactly one result item per sample on
// the m_ stream. Rising midpoint crossings whose slope lies near the steepest
// slope seen are logged as events; when an event matches the first one in
// slope and interval, the intervals logged since are summed (modulo 65536)
// into the period. The peak deviation from 127 is reported per window of
// amplitude_window samples. One item is taken every clock cycle while the result
// stream is not stalled; a result is presented on the m_ stream once its sample
// has landed in the input register and the single-pass update of crossing and
// window state has loaded the result register. A stalled result
// holds the input stage: once both registers are full, s_tready is low in every
// cycle in which m_tready is low. Configuration may only be written while no
// item is in flight.
`include "slope_matched_period_detector_macros.svh"

module slope_matched_period_detector #(
    parameter int unsigned EVENT_SLOTS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] trigger, [16:1] period, [24:17] peak_amplitude, rest 0
    output logic [1:0]  m_tuser,   // [0] period_valid, [1] amp_valid
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  slope_tol_reg;
    logic [15:0] interval_tol_reg;
    logic [15:0] amp_window_reg;
    logic [spd_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic cfg_write;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_sample_reg;
    logic       out_valid_reg, out_valid_next;
    spd_pkg::spd_period_res_t out_period_reg, period_res;
    spd_pkg::spd_amp_res_t    out_amp_reg, amp_res;

    logic out_free;
    logic advance;
    logic s_accept;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_tol_reg    <= spd_pkg::SLOPE_TOL_RST;
            interval_tol_reg <= spd_pkg::INTERVAL_TOL_RST;
            amp_window_reg   <= spd_pkg::AMP_WINDOW_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                spd_pkg::REG_SLOPE_TOL:    slope_tol_reg    <= pwdata[7:0];
                spd_pkg::REG_INTERVAL_TOL: interval_tol_reg <= pwdata[15:0];
                spd_pkg::REG_AMP_WINDOW:   amp_window_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            spd_pkg::REG_SLOPE_TOL:    prdata = {24'd0, slope_tol_reg};
            spd_pkg::REG_INTERVAL_TOL: prdata = {16'd0, interval_tol_reg};
            spd_pkg::REG_AMP_WINDOW:   prdata = {16'd0, amp_window_reg};
            default:                   prdata = '0;
        endcase
    end

    // Pipeline handshake: advance the input stage when the result slot frees up
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload until the stage moves on
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= s_tdata;
        end
        if (advance) begin
            out_period_reg <= period_res;
            out_amp_reg    <= amp_res;
        end
    end

    spd_period #(
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_period (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .sample       (in_sample_reg),
        .slope_tol    (slope_tol_reg),
        .interval_tol (interval_tol_reg),
        .res          (period_res)
    );

    spd_amp u_amp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .sample     (in_sample_reg),
        .amp_window (amp_window_reg),
        .res        (amp_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_amp_reg.peak, out_period_reg.period, out_period_reg.trigger};
    assign m_tuser  = {out_amp_reg.amp_valid, out_period_reg.period_valid};

    // A new period always comes with a trigger
    `SPD_ASSERT_SAME(a_period_has_trigger, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[0])
    // Peak deviation from 127 never exceeds 128
    `SPD_ASSERT_SAME(a_peak_range, aclk, aresetn, m_tvalid, m_tdata[24:17] <= 8'd128)
    // An item accepted into a full input stage requires that stage to move on
    `SPD_ASSERT_SAME(a_no_overwrite, aclk, aresetn, s_accept && in_valid_reg, advance)
    // A moved item shows up as a valid result on the next cycle
    `SPD_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)

endmodule

### tb/sv/slope_matched_period_detector_test.sv
// Self-checking testbench for the slope-matched period detector stream block.
`timescale 1ns / 1ps

module slope_matched_period_detector_test;

    localparam int unsigned EVENT_SLOTS  = 10;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned ITEMS_PER_PHASE = 60;

    typedef struct {
        logic        trigger;
        logic        period_valid;
        logic [15:0] period;
        logic        amp_valid;
        logic [7:0]  peak_amplitude;
    } detector_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;   // [0] trigger, [16:1] period, [24:17] peak_amplitude, rest 0
    logic [1:0]  m_tuser;   // [0] period_valid, [1] amp_valid
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted configuration
    logic [7:0]  cur_slope_tol;
    logic [15:0] cur_gap_tol;
    logic [15:0] cur_amp_window;

    // Predicted crossing and window state
    logic [7:0]  prev_sample;
    logic [15:0] since_crossing;
    logic [15:0] log_gap [EVENT_SLOTS];
    logic [7:0]  log_slope [EVENT_SLOTS];
    int          log_len;
    logic [7:0]  steep_slope;
    int          shallow_run;
    logic [15:0] period_hold;
    logic [15:0] amp_count;
    logic [7:0]  amp_run_max;
    logic [7:0]  amp_held;

    detector_out_t expected_results[$];
    int unsigned   error_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   src_idle_pct = 0;
    int unsigned   sink_stall_pct = 0;
    int unsigned   samples_sent = 0;

    slope_matched_period_detector #(
        .EVENT_SLOTS(EVENT_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int distance(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advance the predicted state by one sample and return the result it causes
    function automatic detector_out_t advance_detector(input logic [7:0] smp);
        detector_out_t res;
        int            slope;
        int            k;
        int            total;
        int            dev;
        logic [7:0]    last;
        res = '{default: '0};
        last = prev_sample;
        prev_sample = smp;
        if (int'(last) < int'(spd_pkg::MIDPOINT) && int'(smp) >= int'(spd_pkg::MIDPOINT)) begin
            slope = int'(smp) - int'(last);
            if (distance(slope, int'(steep_slope)) < int'(cur_slope_tol)) begin
                k = (log_len >= EVENT_SLOTS) ? EVENT_SLOTS - 1 : log_len;
                log_slope[k] = slope[7:0];
                log_gap[k] = since_crossing;
                since_crossing = '0;
                if (k == 0) begin
                    res.trigger = 1'b1;
                    shallow_run = 0;
                    log_len = 1;
                end else if (distance(int'(log_gap[0]), int'(log_gap[k])) < int'(cur_gap_tol) &&
                             distance(int'(log_slope[0]), slope) < int'(cur_slope_tol)) begin
                    total = 0;
                    for (int i = 0; i < k; i++)
                        total += int'(log_gap[i]);
                    period_hold = total[15:0];
                    log_gap[0] = log_gap[k];
                    log_slope[0] = log_slope[k];
                    log_len = 1;
                    res.trigger = 1'b1;
                    res.period_valid = 1'b1;
                    shallow_run = 0;
                end else if (k + 1 > EVENT_SLOTS - 1) begin
                    log_len = 0;
                    shallow_run = 0;
                    steep_slope = '0;
                end else begin
                    log_len = k + 1;
                end
            end else if (slope > int'(steep_slope)) begin
                steep_slope = slope[7:0];
                since_crossing = '0;
                shallow_run = 0;
                log_len = 0;
            end else begin
                shallow_run++;
                if (shallow_run > int'(spd_pkg::MISS_LIMIT)) begin
                    log_len = 0;
                    shallow_run = 0;
                    steep_slope = '0;
                end
            end
        end
        since_crossing = since_crossing + 16'd1;

        // Track the peak deviation over the amplitude window
        amp_count = amp_count + 16'd1;
        dev = distance(int'(spd_pkg::MIDPOINT), int'(smp));
        if (dev > int'(amp_run_max))
            amp_run_max = dev[7:0];
        if (amp_count == cur_amp_window) begin
            amp_count = '0;
            amp_held = amp_run_max;
            amp_run_max = '0;
            res.amp_valid = 1'b1;
        end
        res.period = period_hold;
        res.peak_amplitude = amp_held;
        return res;
    endfunction

    // Source side: idle at random, then hold the item until it is taken
    task automatic send_sample(input logic [7:0] smp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(advance_detector(smp));
        samples_sent++;
    endtask

    // One crossing from lo_end to hi_start, then n-1 more samples ending on lo_end
    task automatic send_segment(input int lo_end, input int hi_start, input int n);
        int highs;
        highs = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                send_sample(hi_start[7:0]);
            else if (i == n - 1)
                send_sample(lo_end[7:0]);
            else if (i < highs)
                send_sample(8'($urandom_range(127, 255)));
            else
                send_sample(8'($urandom_range(0, 126)));
        end
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // Write one register over the configuration port, then read it back
    task automatic program_register(input logic [spd_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] value);
        logic [31:0] mask;
        case (idx)
            spd_pkg::REG_SLOPE_TOL: begin
                mask = 32'h0000_00FF;
                cur_slope_tol = value[7:0];
            end
            spd_pkg::REG_INTERVAL_TOL: begin
                mask = 32'h0000_FFFF;
                cur_gap_tol = value[15:0];
            end
            default: begin
                mask = 32'h0000_FFFF;
                cur_amp_window = value[15:0];
            end
        endcase
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata != (value & mask)) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, value & mask, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Pick an amplitude window a little above the current count so it closes soon
    function automatic logic [31:0] window_ahead(input int lo, input int hi);
        int w;
        w = int'(amp_count) + $urandom_range(lo, hi);
        return (w > 65535) ? 32'd65535 : w;
    endfunction

    // Sample extremes and the basic crossing sequence at reset settings
    task automatic test_crossing_basics();
        logic [7:0] seq [] = '{255, 0, 255, 0, 255, 127, 126, 127, 128, 0,
                               254, 126, 128, 1, 0, 255, 127, 0, 127, 200};
        foreach (seq[i])
            send_sample(seq[i]);
        settle_pipeline();
    endtask

    // Window closing on the next sample, every sample, and at the largest size
    task automatic test_window_settings();
        program_register(spd_pkg::REG_AMP_WINDOW, amp_count + 1);
        send_sample(8'd10);
        send_sample(8'd250);
        settle_pipeline();
        program_register(spd_pkg::REG_AMP_WINDOW, 32'd1);
        send_sample(8'd127);
        send_sample(8'd0);
        send_sample(8'd200);
        settle_pipeline();
        program_register(spd_pkg::REG_AMP_WINDOW, 32'd65535);
        send_sample(8'd64);
        send_sample(8'd190);
        settle_pipeline();
        program_register(spd_pkg::REG_AMP_WINDOW, window_ahead(5, 20));
    endtask

    // Widest tolerances match everything; zero interval tolerance fills the table
    task automatic test_tolerance_extremes();
        program_register(spd_pkg::REG_SLOPE_TOL, 32'd255);
        program_register(spd_pkg::REG_INTERVAL_TOL, 32'd65535);
        send_sample(8'd0);
        send_segment(0, 255, 3);
        for (int i = 0; i < 5; i++)
            send_segment($urandom_range(100, 126), $urandom_range(127, 200), $urandom_range(2, 6));
        settle_pipeline();
        program_register(spd_pkg::REG_INTERVAL_TOL, 32'd0);
        program_register(spd_pkg::REG_SLOPE_TOL, 32'd3);
        send_sample(8'd20);
        for (int i = 0; i < 12; i++)
            send_segment(20, 220, 2 + (i % 3));
        settle_pipeline();
        program_register(spd_pkg::REG_INTERVAL_TOL, 32'(spd_pkg::INTERVAL_TOL_RST));
    endtask

    // Shallow crossings force a soft reset; then a period summed over nine intervals
    task automatic test_soft_reset_period();
        program_register(spd_pkg::REG_SLOPE_TOL, 32'd0);
        // drop to a soft reset through shallow crossings that cannot match
        send_sample(8'd126);
        for (int i = 0; i < 11; i++)
            send_segment(126, 127, 2);
        settle_pipeline();
        program_register(spd_pkg::REG_SLOPE_TOL, 32'd3);
        program_register(spd_pkg::REG_INTERVAL_TOL, 32'd1);
        send_sample(8'd0);
        send_segment(0, 200, 5);
        for (int i = 1; i <= 8; i++)
            send_segment(0, 200, 5 + i);
        send_segment(0, 200, 5);
        send_sample(8'd200);
        settle_pipeline();
        program_register(spd_pkg::REG_INTERVAL_TOL, 32'(spd_pkg::INTERVAL_TOL_RST));
    endtask

    // Random settings, mostly narrow tolerances with the occasional extreme
    task automatic shuffle_settings();
        int pick;
        pick = $urandom_range(0, 9);
        program_register(spd_pkg::REG_SLOPE_TOL, (pick == 0) ? 32'd0 :
                                                 (pick == 1) ? 32'd255 : $urandom_range(1, 8));
        pick = $urandom_range(0, 9);
        program_register(spd_pkg::REG_INTERVAL_TOL, (pick == 0) ? 32'd0 :
                                                    (pick == 1) ? 32'd65535 :
                                                    $urandom_range(1, 12));
        program_register(spd_pkg::REG_AMP_WINDOW, window_ahead(1, 60));
    endtask

    // Mostly periodic crossing patterns, plus non-matching gaps, shallow runs and noise
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned target;
        int          kind;
        int          lo;
        int          hi;
        int          reps;
        int          parts;
        int          gap;
        int          lens [3];
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        shuffle_settings();
        target = samples_sent + ITEMS_PER_PHASE;
        while (samples_sent < target) begin
            kind = $urandom_range(0, 99);
            lo = $urandom_range(0, 120);
            hi = $urandom_range(127, 250);
            send_sample(lo[7:0]);
            if (kind < 50) begin
                parts = $urandom_range(1, 3);
                reps = $urandom_range(3, 6);
                foreach (lens[i])
                    lens[i] = $urandom_range(2, 20);
                for (int r = 0; r < reps; r++)
                    for (int p = 0; p < parts; p++)
                        send_segment(lo + $urandom_range(0, 1), hi + $urandom_range(0, 1),
                                     lens[p] + $urandom_range(0, 2));
            end else if (kind < 65) begin
                // Two short gaps, then gaps that stay clear of the first interval
                gap = 2;
                for (int i = 0; i < 11; i++) begin
                    send_segment(lo, hi, gap);
                    if (i >= 1)
                        gap = 3 + ((cur_gap_tol > 16'd12) ? 12 : int'(cur_gap_tol))
                              + $urandom_range(0, 2);
                end
            end else if (kind < 80) begin
                send_segment(0, 255, $urandom_range(2, 6));
                for (int i = 0; i < 12; i++)
                    send_segment($urandom_range(120, 126), $urandom_range(127, 130),
                                 $urandom_range(2, 4));
            end else begin
                repeat ($urandom_range(4, 30))
                    send_sample(8'($urandom_range(0, 255)));
            end
        end
        settle_pipeline();
    endtask

    // Receiver: stall at random according to the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Compare each result item with the oldest prediction
    always @(posedge aclk) begin : result_checker
        detector_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item: tdata %0h tuser %0h", m_tdata, m_tuser);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.trigger) begin
                    $error("trigger: expected %0d, actual %0d", want.trigger, m_tdata[0]);
                    error_count++;
                end
                if (m_tuser[0] !== want.period_valid) begin
                    $error("period_valid: expected %0d, actual %0d",
                           want.period_valid, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata[16:1] !== want.period) begin
                    $error("period: expected %0d, actual %0d", want.period, m_tdata[16:1]);
                    error_count++;
                end
                if (m_tuser[1] !== want.amp_valid) begin
                    $error("amp_valid: expected %0d, actual %0d", want.amp_valid, m_tuser[1]);
                    error_count++;
                end
                if (m_tdata[24:17] !== want.peak_amplitude) begin
                    $error("peak_amplitude: expected %0d, actual %0d",
                           want.peak_amplitude, m_tdata[24:17]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("slope_matched_period_detector_test: FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        cur_slope_tol = spd_pkg::SLOPE_TOL_RST;
        cur_gap_tol = spd_pkg::INTERVAL_TOL_RST;
        cur_amp_window = spd_pkg::AMP_WINDOW_RST;
        prev_sample = '0;
        since_crossing = '0;
        foreach (log_gap[i]) begin
            log_gap[i] = '0;
            log_slope[i] = '0;
        end
        log_len = 0;
        steep_slope = '0;
        shallow_run = 0;
        period_hold = '0;
        amp_count = '0;
        amp_run_max = '0;
        amp_held = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_crossing_basics();
        test_window_settings();
        test_tolerance_extremes();
        test_soft_reset_period();
        test_random_traffic(0, 0);
        test_random_traffic(61, 0);
        test_random_traffic(0, 61);
        test_random_traffic(38, 38);

        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("slope_matched_period_detector_test: PASS");
        else
            $display("slope_matched_period_detector_test: FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/spd_pkg.sv
rtl/spd_period.sv
rtl/spd_amp.sv
rtl/slope_matched_period_detector.sv
tb/sv/slope_matched_period_detector_test.sv
